/* design/awlm_pkg.sv */
// Shared types and constants for the windowed audio level meter.
// No dependencies; used by awlm_ram and audio_window_level_meter.
package awlm_pkg;

  // Default sample store depth
  localparam int unsigned StoreDepthDefault = 65536;

  // Field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RATE_W   = 18;
  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned LEVEL_W  = 21;
  localparam int unsigned STATUS_W = 2;

  // Time to index arithmetic widths
  localparam int unsigned SCALE_W = RATE_W + CHAN_W;        // rate * channels
  localparam int unsigned TSUM_W  = TIME_W + 1;             // start + duration
  localparam int unsigned PROD_W  = TSUM_W + SCALE_W;       // t * scale
  localparam int unsigned IDX_W   = PROD_W + 1 - 16;        // rounded index

  // Square root working width (mean square stays below 2^41)
  localparam int unsigned RT_W    = 2 * LEVEL_W;

  // Magnitudes at or above this limit are skipped (above 1.001 in Q3.20)
  localparam logic [SAMPLE_W-1:0] SKIP_LIMIT = 24'd1049625;

  // Register reset values
  localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;
  localparam logic [CHAN_W-1:0] CHAN_RESET = 4'd1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic CFG_RATE = 1'b0;
  localparam logic CFG_CHAN = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NODATA = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;

endpackage

/* design/audio_window_level_meter.sv */
// Windowed audio level meter: sample store plus mean / RMS / peak query.
// Clear and load give no result and leave busy_o low. A scanned query raises done_o
// once the serial multiplier, the shared bit-serial divider and the root loop are
// through; zero channels skip the alignment divide. busy_o holds requests off meanwhile.
// Reset (rst_ni low, asynchronous) empties the store and restores the registers.
module audio_window_level_meter
  import awlm_pkg::*;
#(
  parameter int unsigned StoreDepth = StoreDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command request
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [SAMPLE_W-1:0]  sample_value_i,
  input  logic [TIME_W-1:0]    start_time_i,
  input  logic [TIME_W-1:0]    window_length_i,
  // result
  output logic                 done_o,
  output logic [LEVEL_W-1:0]   mean_level_o,
  output logic [LEVEL_W-1:0]   rms_level_o,
  output logic [LEVEL_W-1:0]   peak_level_o,
  output logic [STATUS_W-1:0]  status_o,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [RATE_W-1:0]    cfg_data_i
);

  localparam int unsigned AW    = $clog2(StoreDepth);
  localparam int unsigned CW    = $clog2(StoreDepth + 1);
  localparam int unsigned SUM_W = LEVEL_W + AW + 1;
  localparam int unsigned DIV_W = 2 * LEVEL_W + AW;
  localparam int unsigned DV_W  = AW + 1;
  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_IDX, S_DIV, S_ALIGN, S_CLAMP,
    S_SCAN, S_MEAN, S_MSQ, S_ROOTLD, S_ROOT
  } state_e;

  state_e state_q, ret_q;

  logic [RATE_W-1:0]  rate_q;
  logic [CHAN_W-1:0]  chan_q;
  logic [CW-1:0]      count_q;

  logic [TIME_W-1:0]  t0_q, len_q;
  logic               phase_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [PROD_W-1:0]  acc_q, t_sh_q;
  logic [SCALE_W-1:0] scale_sh_q;
  logic [IDX_W-1:0]   idx_q;
  logic [AW-1:0]      start_q, end_q, rd_addr_q;

  logic               rd_valid_q, mv_q, sv_q;
  logic [LEVEL_W-1:0] mag_q, peak_q, mean_q;
  logic [RT_W-1:0]    sq_q;
  logic [SUM_W-1:0]   sum_q;
  logic [DIV_W-1:0]   sqsum_q;

  logic [DIV_W-1:0]   div_quo_q;
  logic [DV_W-1:0]    div_rem_q, div_dsr_q;

  logic [RT_W-1:0]    x_q, r_q, bit_q;

  logic               done_q;
  logic [LEVEL_W-1:0] mean_out_q, rms_out_q, peak_out_q;
  logic [STATUS_W-1:0] status_q;

  logic [SAMPLE_W-1:0] rdata;

  // Request decode and store write
  logic accept, ram_we, full;
  assign busy_o      = (state_q != S_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = !busy_o;
  assign full        = (count_q == CW'(StoreDepth));
  assign ram_we      = accept && (operation_i == OP_LOAD) && !full;

  awlm_ram #(
    .Width (SAMPLE_W),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (sample_value_i),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata)
  );

  // Scale and time to index rounding
  logic [SCALE_W-1:0] scale;
  logic [PROD_W:0]    rnd;
  logic [IDX_W-1:0]   last, clamp_w;
  logic [AW-1:0]      clamped;
  assign scale   = SCALE_W'(rate_q) * SCALE_W'(chan_q);
  assign rnd     = {1'b0, acc_q} + (PROD_W+1)'(32'h8000);
  assign last    = IDX_W'(count_q) - IDX_W'(1);
  assign clamp_w = (idx_q > last) ? last : idx_q;
  assign clamped = clamp_w[AW-1:0];

  // Shared divider step
  logic [DV_W:0] div_tmp, div_diff;
  logic          div_ge;
  assign div_tmp  = {div_rem_q, div_quo_q[DIV_W-1]};
  assign div_ge   = div_tmp >= {1'b0, div_dsr_q};
  assign div_diff = div_tmp - {1'b0, div_dsr_q};

  // Window length and rounding half
  logic [DV_W-1:0] n_w, half_w;
  assign n_w    = {1'b0, end_q} - {1'b0, start_q};
  assign half_w = n_w >> 1;

  // Sample magnitude
  logic [SAMPLE_W-1:0] mag24;
  logic                keep;
  assign mag24 = rdata[SAMPLE_W-1] ? (~rdata + SAMPLE_W'(1)) : rdata;
  assign keep  = mag24 < SKIP_LIMIT;

  // Square root step
  logic [RT_W:0] rt_sum;
  logic          rt_ge;
  logic [RT_W-1:0] r_fin;
  assign rt_sum = {1'b0, r_q} + {1'b0, bit_q};
  assign rt_ge  = {1'b0, x_q} >= rt_sum;
  assign r_fin  = r_q + RT_W'(x_q > r_q);

  // Sequencer, datapath and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ret_q      <= S_IDLE;
      rate_q     <= RATE_RESET;
      chan_q     <= CHAN_RESET;
      count_q    <= '0;
      t0_q       <= '0;
      len_q      <= '0;
      phase_q    <= 1'b0;
      cnt_q      <= '0;
      acc_q      <= '0;
      t_sh_q     <= '0;
      scale_sh_q <= '0;
      idx_q      <= '0;
      start_q    <= '0;
      end_q      <= '0;
      rd_addr_q  <= '0;
      rd_valid_q <= 1'b0;
      mv_q       <= 1'b0;
      sv_q       <= 1'b0;
      mag_q      <= '0;
      peak_q     <= '0;
      mean_q     <= '0;
      sq_q       <= '0;
      sum_q      <= '0;
      sqsum_q    <= '0;
      div_quo_q  <= '0;
      div_rem_q  <= '0;
      div_dsr_q  <= '0;
      x_q        <= '0;
      r_q        <= '0;
      bit_q      <= '0;
      done_q     <= 1'b0;
      mean_out_q <= '0;
      rms_out_q  <= '0;
      peak_out_q <= '0;
      status_q   <= STAT_OK;
    end else begin
      done_q <= 1'b0;

      // Register writes
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_RATE: rate_q <= cfg_data_i;
          CFG_CHAN: chan_q <= cfg_data_i[CHAN_W-1:0];
          default:  ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            t0_q  <= start_time_i;
            len_q <= window_length_i;
            case (operation_i)
              OP_CLEAR: count_q <= '0;
              OP_LOAD: begin
                if (!full) count_q <= count_q + CW'(1);
              end
              OP_QUERY: begin
                if (count_q == '0 || window_length_i[TIME_W-1]) begin
                  done_q     <= 1'b1;
                  mean_out_q <= '0;
                  rms_out_q  <= '0;
                  peak_out_q <= '0;
                  status_q   <= STAT_NODATA;
                end else begin
                  phase_q    <= 1'b0;
                  acc_q      <= '0;
                  t_sh_q     <= PROD_W'(start_time_i);
                  scale_sh_q <= scale;
                  cnt_q      <= '0;
                  state_q    <= S_MUL;
                end
              end
              default: ;
            endcase
          end
        end

        // Shift and add multiply: time by rate*channels
        S_MUL: begin
          if (scale_sh_q[0]) acc_q <= acc_q + t_sh_q;
          t_sh_q     <= t_sh_q << 1;
          scale_sh_q <= scale_sh_q >> 1;
          cnt_q      <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(SCALE_W - 1)) state_q <= S_IDX;
        end

        // Round, then align down to a channel multiple when the channel count is nonzero
        S_IDX: begin
          idx_q <= rnd[PROD_W:16];
          if (chan_q != '0) begin
            div_quo_q <= DIV_W'(rnd[PROD_W:16]);
            div_rem_q <= '0;
            div_dsr_q <= DV_W'(chan_q);
            cnt_q     <= '0;
            ret_q     <= S_ALIGN;
            state_q   <= S_DIV;
          end else begin
            state_q <= S_CLAMP;
          end
        end

        // Restoring divide, one quotient bit a cycle
        S_DIV: begin
          div_quo_q <= {div_quo_q[DIV_W-2:0], div_ge};
          div_rem_q <= div_ge ? div_diff[DV_W-1:0] : div_tmp[DV_W-1:0];
          cnt_q     <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(DIV_W - 1)) state_q <= ret_q;
        end

        S_ALIGN: begin
          idx_q   <= idx_q - IDX_W'(div_rem_q);
          state_q <= S_CLAMP;
        end

        S_CLAMP: begin
          if (!phase_q) begin
            start_q    <= clamped;
            phase_q    <= 1'b1;
            acc_q      <= '0;
            t_sh_q     <= PROD_W'(t0_q) + PROD_W'(len_q);
            scale_sh_q <= scale;
            cnt_q      <= '0;
            state_q    <= S_MUL;
          end else begin
            end_q <= clamped;
            if (clamped <= start_q) begin
              done_q     <= 1'b1;
              mean_out_q <= '0;
              rms_out_q  <= '0;
              peak_out_q <= '0;
              status_q   <= STAT_EMPTY;
              state_q    <= S_IDLE;
            end else begin
              rd_addr_q <= start_q;
              sum_q     <= '0;
              sqsum_q   <= '0;
              peak_q    <= '0;
              state_q   <= S_SCAN;
            end
          end
        end

        // Stream the window: read, magnitude, square, accumulate
        S_SCAN: begin
          rd_valid_q <= (rd_addr_q != end_q);
          if (rd_addr_q != end_q) rd_addr_q <= rd_addr_q + AW'(1);
          mv_q  <= rd_valid_q && keep;
          mag_q <= mag24[LEVEL_W-1:0];
          sv_q  <= mv_q;
          sq_q  <= RT_W'(mag_q) * RT_W'(mag_q);
          if (mv_q) begin
            sum_q <= sum_q + SUM_W'(mag_q);
            if (mag_q > peak_q) peak_q <= mag_q;
          end
          if (sv_q) sqsum_q <= sqsum_q + DIV_W'(sq_q);
          if (rd_addr_q == end_q && !rd_valid_q && !mv_q && !sv_q) state_q <= S_MEAN;
        end

        S_MEAN: begin
          div_quo_q <= DIV_W'(sum_q + SUM_W'(half_w));
          div_rem_q <= '0;
          div_dsr_q <= n_w;
          cnt_q     <= '0;
          ret_q     <= S_MSQ;
          state_q   <= S_DIV;
        end

        S_MSQ: begin
          mean_q    <= div_quo_q[LEVEL_W-1:0];
          div_quo_q <= sqsum_q + DIV_W'(half_w);
          div_rem_q <= '0;
          div_dsr_q <= n_w;
          cnt_q     <= '0;
          ret_q     <= S_ROOTLD;
          state_q   <= S_DIV;
        end

        S_ROOTLD: begin
          x_q     <= div_quo_q[RT_W-1:0];
          r_q     <= '0;
          bit_q   <= RT_W'(1) << (RT_W - 2);
          cnt_q   <= '0;
          state_q <= S_ROOT;
        end

        // Digit by digit square root, then round to nearest
        S_ROOT: begin
          if (cnt_q == CNT_W'(LEVEL_W)) begin
            done_q     <= 1'b1;
            mean_out_q <= mean_q;
            rms_out_q  <= r_fin[LEVEL_W-1:0];
            peak_out_q <= peak_q;
            status_q   <= STAT_OK;
            state_q    <= S_IDLE;
          end else begin
            if (rt_ge) begin
              x_q <= x_q - rt_sum[RT_W-1:0];
              r_q <= (r_q >> 1) + bit_q;
            end else begin
              r_q <= r_q >> 1;
            end
            bit_q <= bit_q >> 2;
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o       = done_q;
  assign mean_level_o = mean_out_q;
  assign rms_level_o  = rms_out_q;
  assign peak_level_o = peak_out_q;
  assign status_o     = status_q;

endmodule

/* design/awlm_ram.sv */
// Generic single write port, single read port RAM with registered read.
// Depends on awlm_pkg for the default Width and Depth parameters.
module awlm_ram
  import awlm_pkg::*;
#(
  parameter int unsigned Width = SAMPLE_W,
  parameter int unsigned Depth = StoreDepthDefault
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
